// File: hw/rtl/fcf_pkg.sv
// Shared constants for the feedforward comb filter.
// No dependencies; imported by the comb filter top level.
package fcf_pkg;

    // Field widths that the register map fixes.
    localparam int DELAY_W     = 12;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC_W = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY  = 2'd0,
        CFG_GAIN   = 2'd1,
        CFG_INVERT = 2'd2,
        CFG_SPARE  = 2'd3
    } cfg_idx_t;

endpackage

// File: hw/rtl/fcf_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Standalone; a same-cycle read of the written address returns the old data.
module fcf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/feedforward_comb_filter.sv
// Feedforward comb filter top level: delay memory, gain multiplier, saturating adder.
// Depends on fcf_pkg and on the generic RAM fcf_ram.
//
//   channel | valid     | stall     | payload                 | direction
//   --------+-----------+-----------+-------------------------+----------
//   in      | in_valid  | in_stall  | sample_in               | into block
//   out     | out_valid | out_stall | sample_out, clipped     | out of block
//   cfg     | cfg_write | (none)    | cfg_index, cfg_data     | into block
//
// One request is accepted per cycle while in_stall is low. The delay memory
// read is registered with the request in the memory stage, then the result
// in the output register, from which it is taken when out_stall is low. The
// single delay memory port pair, one read and one write per request, sets that rate.
// Reset clears control state only; the delay memory is not swept. A fill flag
// marks entries never written since reset, and those read as zero.
// While the output register is held by out_stall, the memory stage behind it holds
// too and, once it holds a request, in_stall rises, so no request is lost or repeated.
module feedforward_comb_filter #(
    parameter int DEPTH       = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port.
    input  logic                                 cfg_write,
    input  logic [fcf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fcf_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Input channel.
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        sample_in,
    // Output channel.
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_BITS-1:0]        sample_out,
    output logic                                 clipped
);

    import fcf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = SAMPLE_BITS + 1;
    localparam int PW = SAMPLE_BITS + GAIN_W + 1;
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Reduce a delay to the memory depth by restoring subtraction of
    // shifted copies of DEPTH; most steps fold away at elaboration.
    function automatic logic [AW-1:0] reduce_delay(input logic [DELAY_W-1:0] val);
        logic [31:0] r;
        r = 32'(val);
        for (int i = DELAY_W - 1; i >= 0; i--)
        begin
            if (r >= (32'(DEPTH) << i))
            begin
                r = r - (32'(DEPTH) << i);
            end
        end
        return r[AW-1:0];
    endfunction

    // Configuration registers. The delay is stored already reduced.
    logic [AW-1:0]     delay_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              invert_reg;

    // Write position and the flag that says every entry has been written.
    logic [AW-1:0] wpos_reg, wpos_next;
    logic          filled_reg, filled_next;

    // Memory stage: request waits for read data.
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    logic                          s1_hit_reg;

    // Output register.
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic                          clipped_reg;

    logic accept;
    logic s1_advance;
    logic [AW-1:0] rd_addr;
    logic          rd_hit;
    logic signed [PW-1:0]          product;
    logic signed [PW-1:0]          prod_shift;
    logic signed [SAMPLE_BITS-1:0] scaled;
    logic signed [SAMPLE_BITS-1:0] store_val;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS-1:0] delayed;
    logic signed [SW-1:0]          sum;
    logic                          overflow;

    // The memory stage moves on when the output register is free or drains.
    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign accept     = in_valid && !in_stall;

    // Read index: write position minus delay, modulo DEPTH. A zero delay
    // reads the entry about to be overwritten, a full buffer old.
    always_comb
    begin
        if (wpos_reg >= delay_reg)
        begin
            rd_addr = wpos_reg - delay_reg;
        end
        else
        begin
            rd_addr = AW'(32'(wpos_reg) + 32'(DEPTH) - 32'(delay_reg));
        end
        // Entries are written in order from zero, so anything below the
        // write position has been written since reset.
        rd_hit = filled_reg || (rd_addr < wpos_reg);
    end

    // Scaled sample for the delay line: arithmetic shift gives floor.
    always_comb
    begin
        product    = PW'(sample_in) * PW'($signed({1'b0, gain_reg}));
        prod_shift = product >>> GAIN_FRAC_W;
        scaled     = prod_shift[SAMPLE_BITS-1:0];
        store_val  = invert_reg ? -scaled : scaled;
    end

    always_comb
    begin
        if (wpos_reg == LAST_POS)
        begin
            wpos_next   = '0;
            filled_next = 1'b1;
        end
        else
        begin
            wpos_next   = wpos_reg + AW'(1);
            filled_next = filled_reg;
        end
    end

    // Read and write of the same entry in one cycle return the old data,
    // matching read-before-write order of a single request.
    fcf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (wpos_reg),
        .wdata (store_val),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Sum with saturation to the sample range.
    always_comb
    begin
        delayed  = s1_hit_reg ? $signed(ram_rdata) : '0;
        sum      = SW'(s1_x_reg) + SW'(delayed);
        overflow = sum[SW-1] != sum[SW-2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= '0;
            gain_reg      <= '0;
            invert_reg    <= 1'b0;
            wpos_reg      <= '0;
            filled_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_DELAY:  delay_reg  <= reduce_delay(cfg_data[DELAY_W-1:0]);
                    CFG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                    CFG_INVERT: invert_reg <= cfg_data[0];
                    default:    ;
                endcase
            end
            if (accept)
            begin
                wpos_reg   <= wpos_next;
                filled_reg <= filled_next;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg   <= sample_in;
            s1_hit_reg <= rd_hit;
        end
        if (s1_advance && s1_valid_reg)
        begin
            clipped_reg <= overflow;
            if (overflow)
            begin
                sample_out_reg <= sum[SW-1] ? SMIN : SMAX;
            end
            else
            begin
                sample_out_reg <= sum[SAMPLE_BITS-1:0];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

    // A stalled input means a request is parked in the memory stage.
    a_stall_has_owner: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with no request blocking it");

    // A blocked memory stage keeps its request and sample.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall)
        |=> (s1_valid_reg && $stable(s1_x_reg)))
        else $error("memory stage lost its request under stall");

    // The write position steps by one per accepted request.
    a_wpos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && wpos_reg != LAST_POS) |=> (wpos_reg == $past(wpos_reg) + AW'(1)))
        else $error("write position did not advance");

    // A clipped result sits at one of the bounds.
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && clipped_reg) |-> (sample_out_reg == SMAX || sample_out_reg == SMIN))
        else $error("clipped result not at a bound");

endmodule
